[rtl/min_priority_queue_macros.svh]
// Assertion macros shared by the min_priority_queue checker.
// No dependencies; include by bare file name.
`ifndef MIN_PRIORITY_QUEUE_MACROS_SVH
`define MIN_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MPQ_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("min_priority_queue check failed");

// Next-cycle implication, disabled during reset.
`define MPQ_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("min_priority_queue check failed");

`endif

[rtl/mpq_pkg.sv]
// Types and constants for the min_priority_queue block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mpq_pkg;

   // beat kinds
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   // width of the reported entry count
   localparam int HELD_W = 5;

   typedef struct packed {
      logic               kind;
      logic signed [31:0] item_value;
      logic signed [31:0] item_priority;
   } req_type;

   typedef struct packed {
      logic signed [31:0] removed_value;
      logic signed [31:0] removed_priority;
      logic               removed_valid;
      logic               op_error;
      logic [HELD_W-1:0]  entries_held;
      logic               is_empty;
      logic               is_full;
      logic signed [31:0] least_priority;
   } rsp_type;

   // one stored pair
   typedef struct packed {
      logic signed [31:0] value;
      logic signed [31:0] prio;
   } entry_type;

   // controls broadcast to every cell
   typedef struct packed {
      logic shift;   // take the neighbor's entry
      logic load;    // the target cell takes the bus entry
   } cell_ctl_type;

endpackage

`default_nettype wire

[rtl/mpq_cell.sv]
// One storage cell of the queue chain: holds a pair, loads from the bus or its neighbor.
// Depends on mpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpq_cell import mpq_pkg::*; #(
   parameter int IDXW  = 4,
   parameter int INDEX = 0
) (
   input  wire logic              clock,
   input  wire cell_ctl_type      ctl,
   input  wire logic [IDXW-1:0]   tgt,
   input  wire entry_type         bus,
   input  wire entry_type         nbr,
   output entry_type              q
);

   entry_type ent_ff;
   entry_type ent_in;
   logic      hit;

   // bus load wins over the neighbor shift
   assign hit = ctl.load && (tgt == IDXW'(INDEX));

   always_comb begin
      if (hit) begin
         ent_in = bus;
      end else if (ctl.shift) begin
         ent_in = nbr;
      end else begin
         ent_in = ent_ff;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign q = ent_ff;

endmodule

`default_nettype wire

[rtl/min_priority_queue.sv]
// Minimum-priority queue of (value, priority) pairs: top level with controller and cell chain.
// Depends on mpq_pkg and mpq_cell.
`timescale 1ns / 1ps
`default_nettype none

// Entries sit in a row of CAPACITY cells in arrival order, and the smallest
// held priority is kept in a register, so every result carries the peek value.
// An insert, or any beat flagged as an error, is handled in the idle state: the
// next beat can be taken once its result can leave the output register. A remove
// rotates the whole chain one cell per cycle past the head comparator, which
// drops the earliest entry holding the smallest priority and works out the new
// minimum from the entries it keeps; the done state then posts the result. No
// reset sweep is needed. Each result waits in an output register, so a stalled
// result channel only blocks the next beat, not the work in flight.
module min_priority_queue import mpq_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNTW = $clog2(CAPACITY + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]         state_ff,      state_in;
   logic [CNTW-1:0]    occ_ff,        occ_in;
   logic [CNTW-1:0]    steps_ff,      steps_in;
   logic signed [31:0] least_ff,      least_in;
   logic signed [31:0] newmin_ff,     newmin_in;
   logic               have_ff,       have_in;
   logic               found_ff,      found_in;
   entry_type          rem_ff,        rem_in;
   logic               rsp_valid_ff,  rsp_valid_in;
   rsp_type            rsp_data_ff,   rsp_data_in;

   entry_type          cell_q [CAPACITY];
   entry_type          head;
   entry_type          bus;
   cell_ctl_type       ctl;
   logic [IDXW-1:0]    tgt;
   logic [CNTW-1:0]    occ_m1;
   logic               out_free;
   logic               req_fire;
   logic               is_target;
   logic               ins_ok;

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // head of the chain and the removal match
   assign head      = cell_q[0];
   assign is_target = !found_ff && (head.prio == least_ff);
   assign occ_m1    = occ_ff - CNTW'(1);
   assign ins_ok    = req_fire && (req_data.kind == KIND_INSERT)
                      && (occ_ff != CNTW'(CAPACITY));

   // cell controls: insert appends at the tail, a scan step rotates
   always_comb begin
      ctl.shift = (state_ff == ST_SCAN);
      if (state_ff == ST_SCAN) begin
         ctl.load = !is_target;
         tgt      = occ_m1[IDXW-1:0];
         bus      = head;
      end else begin
         ctl.load = ins_ok;
         tgt      = occ_ff[IDXW-1:0];
         bus      = '{value: req_data.item_value, prio: req_data.item_priority};
      end
   end

   // cell chain
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type nbr;
      if (i == CAPACITY - 1) begin : g_last
         assign nbr = cell_q[i];
      end else begin : g_mid
         assign nbr = cell_q[i+1];
      end
      mpq_cell #(
         .IDXW  (IDXW),
         .INDEX (i)
      ) u_cell (
         .clock (clock),
         .ctl   (ctl),
         .tgt   (tgt),
         .bus   (bus),
         .nbr   (nbr),
         .q     (cell_q[i])
      );
   end

   // controller next state
   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      steps_in     = steps_ff;
      least_in     = least_ff;
      newmin_in    = newmin_ff;
      have_in      = have_ff;
      found_in     = found_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_data_in = '0;
               if (req_data.kind == KIND_INSERT) begin
                  if (occ_ff == CNTW'(CAPACITY)) begin
                     rsp_data_in.op_error = 1'b1;
                  end else begin
                     occ_in = occ_ff + CNTW'(1);
                     if (occ_ff == '0 || req_data.item_priority < least_ff) begin
                        least_in = req_data.item_priority;
                     end
                  end
                  rsp_valid_in = 1'b1;
               end else if (occ_ff == '0) begin
                  rsp_data_in.op_error = 1'b1;
                  rsp_valid_in         = 1'b1;
               end else begin
                  state_in = ST_SCAN;
                  steps_in = occ_ff;
                  found_in = 1'b0;
                  have_in  = 1'b0;
               end
               rsp_data_in.entries_held   = HELD_W'(occ_in);
               rsp_data_in.is_empty       = (occ_in == '0);
               rsp_data_in.is_full        = (occ_in == CNTW'(CAPACITY));
               rsp_data_in.least_priority = (occ_in == '0) ? 32'sd0 : least_in;
            end
         end
         ST_SCAN: begin
            // one rotation step per cycle
            steps_in = steps_ff - CNTW'(1);
            if (is_target) begin
               rem_in   = head;
               found_in = 1'b1;
               occ_in   = occ_m1;
            end else begin
               if (!have_ff || head.prio < newmin_ff) begin
                  newmin_in = head.prio;
               end
               have_in = 1'b1;
            end
            if (steps_ff == CNTW'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               least_in                     = have_ff ? newmin_ff : 32'sd0;
               rsp_data_in.removed_value    = rem_ff.value;
               rsp_data_in.removed_priority = rem_ff.prio;
               rsp_data_in.removed_valid    = 1'b1;
               rsp_data_in.op_error         = 1'b0;
               rsp_data_in.entries_held     = HELD_W'(occ_ff);
               rsp_data_in.is_empty         = (occ_ff == '0);
               rsp_data_in.is_full          = (occ_ff == CNTW'(CAPACITY));
               rsp_data_in.least_priority   = have_ff ? newmin_ff : 32'sd0;
               rsp_valid_in                 = 1'b1;
               state_in                     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         least_ff     <= '0;
         found_ff     <= 1'b0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         least_ff     <= least_in;
         found_ff     <= found_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      steps_ff    <= steps_in;
      newmin_ff   <= newmin_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

[rtl/mpq_checker.sv]
// Port-level checker for min_priority_queue, attached by bind.
// Depends on mpq_pkg and min_priority_queue_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "min_priority_queue_macros.svh"

module mpq_checker import mpq_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   logic ins_beat;
   logic rem_zero;
   logic peek_zero;

   // accepted insert beat, zeroed removal fields, empty-queue peek
   assign ins_beat  = req_valid && !req_stall && (req_data.kind == KIND_INSERT);
   assign rem_zero  = (rsp_data.removed_value == 32'sd0)
                      && (rsp_data.removed_priority == 32'sd0);
   assign peek_zero = (rsp_data.least_priority == 32'sd0) && !rsp_data.is_full;

   // a stalled result beat holds
   `MPQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // an insert beat posts its result on the next cycle
   `MPQ_ASSERT_NEXT(a_ins_result, clock, reset, ins_beat, rsp_valid)

   // a successful remove is never flagged
   `MPQ_ASSERT_IMPL(a_rem_no_err, clock, reset, rsp_valid && rsp_data.removed_valid, !rsp_data.op_error)

   // no removal: removed fields read zero
   `MPQ_ASSERT_IMPL(a_rem_zero, clock, reset, rsp_valid && !rsp_data.removed_valid, rem_zero)

   // empty queue reports zero peek and is not full
   `MPQ_ASSERT_IMPL(a_empty_peek, clock, reset, rsp_valid && rsp_data.is_empty, peek_zero)

endmodule

bind min_priority_queue mpq_checker u_mpq_checker (.*);

`default_nettype wire
